// File: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AESC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("aesc assertion failed");

// expression must never be true outside reset
`define AESC_NEVER(label, expr) \
   `AESC_ASSERT(label, !(expr))

`endif

// File: rtl/aesc_pkg.sv
// types, constants and round functions of the aes-128 ctr block cipher
package aesc_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam logic [3:0] LAST_ROUND = 4'd10;

   // register indexes of the csr port
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW = 2'd1;
   localparam logic [1:0] CSR_NONCE = 2'd2;

   typedef struct packed {
      logic [127:0] ctr_block;
      logic [127:0] text;
      logic [4:0]   valid_bytes;
      logic         no_keystream;
   } q_entry_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } back_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] round_const(input logic [3:0] rnd);
      logic [7:0] rc;
      case (rnd)
         4'd1: rc = 8'h01;
         4'd2: rc = 8'h02;
         4'd3: rc = 8'h04;
         4'd4: rc = 8'h08;
         4'd5: rc = 8'h10;
         4'd6: rc = 8'h20;
         4'd7: rc = 8'h40;
         4'd8: rc = 8'h80;
         4'd9: rc = 8'h1b;
         4'd10: rc = 8'h36;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte 0 sits in the top byte
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   // next round key from the current one
   function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                   input logic [3:0] rnd);
      logic [31:0] w3, tmp, n0, n1, n2, n3;
      w3 = rk[31:0];
      tmp = {SBOX[w3[23:16]] ^ round_const(rnd), SBOX[w3[15:8]], SBOX[w3[7:0]],
             SBOX[w3[31:24]]};
      n0 = rk[127:96] ^ tmp;
      n1 = rk[95:64] ^ n0;
      n2 = rk[63:32] ^ n1;
      n3 = rk[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // clear bytes at or beyond the valid count, counts above sixteen act as sixteen
   function automatic logic [127:0] mask_bytes(input logic [127:0] d,
                                               input logic [4:0] cnt);
      logic [127:0] t;
      t = '0;
      for (int b = 0; b < 16; b++) begin
         if (5'(b) < cnt) begin
            t[127 - 8 * b -: 8] = d[127 - 8 * b -: 8];
         end
      end
      return t;
   endfunction

endpackage

// File: rtl/aesc_if.sv
// request and response channel interfaces
interface aesc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] text_high;
   logic [63:0] text_low;
   logic [4:0]  valid_bytes;
   modport source (output valid, text_high, text_low, valid_bytes, input ready);
   modport sink (input valid, text_high, text_low, valid_bytes, output ready);
endinterface

interface aesc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;
   logic [4:0]  out_valid_bytes;
   modport source (output valid, cipher_high, cipher_low, out_valid_bytes, input ready);
   modport sink (input valid, cipher_high, cipher_low, out_valid_bytes, output ready);
endinterface

// File: rtl/aes128_ctr_block_cipher_top.sv
// top level of the aes-128 ctr block cipher
// Usage:
//   req_chan carries one 16-byte text block per transaction (valid/ready),
//   with a count of leading valid bytes; rsp_chan returns the block XORed
//   with the keystream, bytes past the count read as zero.
//   The csr port writes key_high (0), key_low (1) and nonce_value (2); any
//   such write restarts the block counter at zero. Write only while idle.
// Sequencing:
//   a block waits in the queue, gets the initial key addition when the
//   round-iterative core loads it, and then goes through ten rounds; the
//   last round writes the response register. The single shared round unit
//   takes no new block until the previous one has left its last round. A
//   zero-count block uses no keystream and goes from the queue straight to
//   the response register once the core is idle and that register is free.
// Reset:
//   synchronous, active high; clears the key, nonce, counter, queue
//   pointers and fill count, core busy flag and response valid flag.
// Stalls:
//   a held response keeps the core waiting on its last round; the queue
//   keeps accepting until it is full, then req_chan.ready drops.
`include "assert_macros.svh"

module aes128_ctr_block_cipher_top
   import aesc_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   aesc_req_if.sink    req_chan,
   aesc_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic            q_push;
   logic            q_pop;
   logic            q_full;
   logic            q_not_empty;
   q_entry_type     q_in_entry;
   q_entry_type     q_head;
   logic [127:0]    cipher_key;
   back_status_type back_status;

   // front end
   aesc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_in_entry),
      .cipher_key       (cipher_key)
   );

   // decoupling queue
   aesc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .full       (q_full),
      .head_entry (q_head)
   );

   // back end
   aesc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .cipher_key  (cipher_key),
      .q_pop       (q_pop),
      .status      (back_status),
      .rsp_chan    (rsp_chan)
   );

   // checks
   `AESC_NEVER(a_push_when_full, q_push && q_full)
   `AESC_NEVER(a_pop_while_busy, q_pop && back_status.busy)
   `AESC_ASSERT(a_pop_takes_effect, q_pop |=> (back_status.busy || rsp_chan.valid))
   `AESC_ASSERT(a_finish_shows_result, back_status.finishing |=> rsp_chan.valid)

endmodule

// File: rtl/aesc_front.sv
// front end: csr registers, block counter, transaction classification
module aesc_front
   import aesc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   aesc_req_if.sink      req_chan,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_write_data,
   input  logic          q_full,
   output logic          q_push,
   output q_entry_type   q_entry,
   output logic [127:0]  cipher_key
);

   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] nonce_ff, nonce_in;
   logic [63:0] counter_ff, counter_in;
   logic        csr_hit;

   assign req_chan.ready = !q_full;
   assign q_push = req_chan.valid && !q_full;
   assign cipher_key = {key_high_ff, key_low_ff};

   // classify and tag the incoming transaction
   always_comb begin
      q_entry.ctr_block = {nonce_ff, counter_ff};
      q_entry.text = {req_chan.text_high, req_chan.text_low};
      q_entry.valid_bytes = req_chan.valid_bytes;
      q_entry.no_keystream = (req_chan.valid_bytes == 5'd0);
   end

   // csr writes and counter update
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in = key_low_ff;
      nonce_in = nonce_ff;
      counter_in = counter_ff;
      csr_hit = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_HIGH: begin
               key_high_in = csr_write_data;
               csr_hit = 1'b1;
            end
            CSR_KEY_LOW: begin
               key_low_in = csr_write_data;
               csr_hit = 1'b1;
            end
            CSR_NONCE: begin
               nonce_in = csr_write_data;
               csr_hit = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
      if (csr_hit) begin
         counter_in = '0;
      end else if (q_push && !q_entry.no_keystream) begin
         counter_in = counter_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         nonce_ff <= '0;
         counter_ff <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff <= key_low_in;
         nonce_ff <= nonce_in;
         counter_ff <= counter_in;
      end
   end

endmodule

// File: rtl/aesc_queue.sv
// short queue between front and back end
module aesc_queue
   import aesc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   input  logic        pop,
   output logic        not_empty,
   output logic        full,
   output q_entry_type head_entry
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   q_entry_type entries_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CntWidth'(Depth));
   assign head_entry = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/aesc_back.sv
// back end: round-iterative aes core with on-the-fly key schedule and output register
module aesc_back
   import aesc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   input  q_entry_type     q_head,
   input  logic [127:0]    cipher_key,
   output logic            q_pop,
   output back_status_type status,
   aesc_rsp_if.source      rsp_chan
);

   logic         busy_ff, busy_in;
   logic [3:0]   round_ff, round_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [127:0] text_ff, text_in;
   logic [4:0]   count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] cipher_ff, cipher_in;
   logic [4:0]   out_count_ff, out_count_in;

   logic         out_free;
   logic         last_round;
   logic         advance;
   logic [127:0] rkey_next;
   logic [127:0] round_out;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign last_round = (round_ff == LAST_ROUND);
   assign advance = busy_ff && (!last_round || out_free);
   assign q_pop = !busy_ff && q_not_empty && (!q_head.no_keystream || out_free);

   assign status.busy = busy_ff;
   assign status.finishing = advance && last_round;

   // one aes round per cycle while the core is busy; the last round waits for a free output register
   always_comb begin
      rkey_next = next_round_key(rkey_ff, round_ff);
      if (last_round) begin
         round_out = sub_shift(state_ff) ^ rkey_next;
      end else begin
         round_out = mix_columns(sub_shift(state_ff)) ^ rkey_next;
      end
   end

   // sequencing of load, rounds and result write
   always_comb begin
      busy_in = busy_ff;
      round_in = round_ff;
      state_in = state_ff;
      rkey_in = rkey_ff;
      text_in = text_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      cipher_in = cipher_ff;
      out_count_in = out_count_ff;
      if (q_pop) begin
         if (q_head.no_keystream) begin
            rsp_valid_in = 1'b1;
            cipher_in = '0;
            out_count_in = q_head.valid_bytes;
         end else begin
            busy_in = 1'b1;
            round_in = 4'd1;
            state_in = q_head.ctr_block ^ cipher_key;
            rkey_in = cipher_key;
            text_in = q_head.text;
            count_in = q_head.valid_bytes;
         end
      end else if (advance) begin
         state_in = round_out;
         rkey_in = rkey_next;
         round_in = round_ff + 4'd1;
         if (last_round) begin
            busy_in = 1'b0;
            rsp_valid_in = 1'b1;
            cipher_in = mask_bytes(text_ff ^ round_out, count_ff);
            out_count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      state_ff <= state_in;
      rkey_ff <= rkey_in;
      text_ff <= text_in;
      count_ff <= count_in;
      cipher_ff <= cipher_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.cipher_high = cipher_ff[127:64];
   assign rsp_chan.cipher_low = cipher_ff[63:0];
   assign rsp_chan.out_valid_bytes = out_count_ff;

endmodule
